### sv/ocf_pkg.sv
// ----------------------------------------------------------------------------
// ocf_pkg
// shared types, character codes and lookup functions of the clipboard framer
// ----------------------------------------------------------------------------
package ocf_pkg;

  localparam logic [7:0] ESC_CODE = 8'h1B;
  localparam logic [7:0] BEL_CODE = 8'h07;
  localparam logic [7:0] PAD_CODE = 8'h3D;
  localparam logic [7:0] BSL_CODE = 8'h5C;

  // message channel beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       no_data;
  } ocf_in_t;

  // sequence channel beat
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } ocf_out_t;

  // classified work for the back end, one per accepted beat
  typedef struct packed {
    logic        wrap;
    logic        prefix;
    logic        quad_en;
    logic [2:0]  quad_chars;
    logic [23:0] quad_word;
    logic        last;
  } ocf_cmd_t;

  // standard base64 alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] sextet);
    logic [7:0] c;
    if (sextet < 6'd26) begin
      c = 8'h41 + {2'b00, sextet};
    end else if (sextet < 6'd52) begin
      c = 8'h61 + {2'b00, sextet} - 8'd26;
    end else if (sextet < 6'd62) begin
      c = 8'h30 + {2'b00, sextet} - 8'd52;
    end else if (sextet == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // ESC ] 5 2 ; c ;
  function automatic logic [7:0] osc_prefix_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = ESC_CODE;
      3'd1:    c = 8'h5D;
      3'd2:    c = 8'h35;
      3'd3:    c = 8'h32;
      3'd4:    c = 8'h3B;
      3'd5:    c = 8'h63;
      3'd6:    c = 8'h3B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // ESC P followed by the multiplexer name and ;
  function automatic logic [7:0] pass_prefix_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = ESC_CODE;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h6D;
      3'd4:    c = 8'h75;
      3'd5:    c = 8'h78;
      3'd6:    c = 8'h3B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### sv/ocf_front.sv
// ----------------------------------------------------------------------------
// ocf_front
// accepts message bytes, groups them in threes and issues one command per beat
// ----------------------------------------------------------------------------
module ocf_front import ocf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ocf_in_t  in_data_i,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic     cfg_data_i,
  input  logic     q_full_i,
  output logic     push_o,
  output ocf_cmd_t cmd_o
);

  logic       wrap_q;
  logic [7:0] p0_q, p0_d, p1_q, p1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       msg_q, msg_d;
  logic [1:0] cnt0, cnt1;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign push_o      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o            = '0;
    cmd_o.wrap       = wrap_q;
    cmd_o.prefix     = !msg_q;
    cmd_o.last       = in_data_i.last_byte;
    p0_d             = p0_q;
    p1_d             = p1_q;
    cnt0             = msg_q ? cnt_q : 2'd0;
    cnt1             = cnt0;
    if (!in_data_i.no_data) begin
      if (cnt0 == 2'd2) begin
        cmd_o.quad_en    = 1'b1;
        cmd_o.quad_chars = 3'd4;
        cmd_o.quad_word  = {p0_q, p1_q, in_data_i.data_byte};
        cnt1             = 2'd0;
      end else begin
        if (cnt0[0]) begin
          p1_d = in_data_i.data_byte;
        end else begin
          p0_d = in_data_i.data_byte;
        end
        cnt1 = cnt0 + 2'd1;
      end
    end
    if (in_data_i.last_byte) begin
      // flush the remainder with padding
      if (cnt1 == 2'd1) begin
        cmd_o.quad_en    = 1'b1;
        cmd_o.quad_chars = 3'd2;
        cmd_o.quad_word  = {p0_d, 16'h0000};
      end else if (cnt1 == 2'd2) begin
        cmd_o.quad_en    = 1'b1;
        cmd_o.quad_chars = 3'd3;
        cmd_o.quad_word  = {p0_d, p1_d, 8'h00};
      end
      cnt_d = 2'd0;
      msg_d = 1'b0;
    end else begin
      cnt_d = cnt1;
      msg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= 1'b0;
      cnt_q  <= 2'd0;
      msg_q  <= 1'b0;
      p0_q   <= 8'h00;
      p1_q   <= 8'h00;
    end else begin
      if (cfg_valid_i) begin
        wrap_q <= cfg_data_i;
      end
      if (push_o) begin
        cnt_q <= cnt_d;
        msg_q <= msg_d;
        p0_q  <= p0_d;
        p1_q  <= p1_d;
      end
    end
  end

endmodule

### sv/ocf_queue.sv
// ----------------------------------------------------------------------------
// ocf_queue
// small command queue between the front and back ends
// ----------------------------------------------------------------------------
module ocf_queue import ocf_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ocf_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output ocf_cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ocf_cmd_t        slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

### sv/ocf_back.sv
// ----------------------------------------------------------------------------
// ocf_back
// character sequencer: expands commands into escape sequence bytes
// ----------------------------------------------------------------------------
module ocf_back import ocf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  ocf_cmd_t q_cmd_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ocf_out_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_OSC,
    ST_QUAD,
    ST_BEL,
    ST_CLOSE
  } state_e;

  state_e   state_q, state_d, nxt_state;
  logic [2:0] idx_q, idx_d, nxt_idx;
  logic     dup_q, dup_d, nxt_dup;
  ocf_cmd_t cur_q, cur_d;
  logic     ov_q, ov_d;
  ocf_out_t od_q, od_d;
  logic     adv;
  logic [7:0] ch;
  logic     ch_last;
  logic [5:0] sextet;

  function automatic state_e first_phase(input ocf_cmd_t c);
    state_e s;
    if (c.prefix) begin
      s = c.wrap ? ST_PASS : ST_OSC;
    end else if (c.quad_en) begin
      s = ST_QUAD;
    end else if (c.last) begin
      s = ST_BEL;
    end else begin
      s = ST_IDLE;
    end
    return s;
  endfunction

  assign adv         = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_comb begin
    case (idx_q[1:0])
      2'd0:    sextet = cur_q.quad_word[23:18];
      2'd1:    sextet = cur_q.quad_word[17:12];
      2'd2:    sextet = cur_q.quad_word[11:6];
      default: sextet = cur_q.quad_word[5:0];
    endcase
  end

  // character of the current step and where the sequencer goes next
  always_comb begin
    ch        = 8'h00;
    ch_last   = 1'b0;
    nxt_state = state_q;
    nxt_idx   = idx_q + 3'd1;
    nxt_dup   = 1'b0;
    case (state_q)
      ST_PASS: begin
        ch = pass_prefix_char(idx_q);
        if (idx_q == 3'd6) begin
          nxt_state = ST_OSC;
          nxt_idx   = 3'd0;
        end
      end
      ST_OSC: begin
        ch = osc_prefix_char(idx_q);
        if (idx_q == 3'd0 && cur_q.wrap && !dup_q) begin
          // doubled escape inside the passthrough frame
          nxt_dup = 1'b1;
          nxt_idx = idx_q;
        end else if (idx_q == 3'd6) begin
          nxt_idx   = 3'd0;
          nxt_state = cur_q.quad_en ? ST_QUAD : (cur_q.last ? ST_BEL : ST_IDLE);
        end
      end
      ST_QUAD: begin
        ch = (idx_q < cur_q.quad_chars) ? b64_char(sextet) : PAD_CODE;
        if (idx_q == 3'd3) begin
          nxt_idx   = 3'd0;
          nxt_state = cur_q.last ? ST_BEL : ST_IDLE;
        end
      end
      ST_BEL: begin
        ch        = BEL_CODE;
        ch_last   = !cur_q.wrap;
        nxt_idx   = 3'd0;
        nxt_state = cur_q.wrap ? ST_CLOSE : ST_IDLE;
      end
      ST_CLOSE: begin
        if (idx_q == 3'd0) begin
          ch = ESC_CODE;
        end else begin
          ch        = BSL_CODE;
          ch_last   = 1'b1;
          nxt_state = ST_IDLE;
        end
      end
      default: begin
        nxt_state = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    dup_d   = dup_q;
    cur_d   = cur_q;
    ov_d    = ov_q;
    od_d    = od_q;
    pop_o   = 1'b0;
    if (state_q != ST_IDLE && adv) begin
      ov_d    = 1'b1;
      od_d    = '{out_char: ch, out_last: ch_last};
      state_d = nxt_state;
      idx_d   = nxt_idx;
      dup_d   = nxt_dup;
    end else if (adv) begin
      ov_d = 1'b0;
    end
    // pick up the next command once the current one is finished
    if (state_q == ST_IDLE || (adv && nxt_state == ST_IDLE)) begin
      if (!q_empty_i) begin
        pop_o   = 1'b1;
        cur_d   = q_cmd_i;
        state_d = first_phase(q_cmd_i);
        idx_d   = 3'd0;
        dup_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 3'd0;
      dup_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      dup_q   <= dup_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    od_q  <= od_d;
  end

  a_last_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_last |->
      out_data_o.out_char == BEL_CODE || out_data_o.out_char == BSL_CODE)
    else $error("sequence end flagged on a non-closing byte");

  a_dup_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dup_q |-> state_q == ST_OSC && cur_q.wrap && idx_q == 3'd0)
    else $error("escape doubling outside the inner prefix");

  a_quad_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_QUAD |-> cur_q.quad_en && cur_q.quad_chars >= 3'd2)
    else $error("base64 group without a group command");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !q_empty_i)
    else $error("command taken from empty queue");

endmodule

### sv/osc52_base64_clipboard_framer.sv
// ----------------------------------------------------------------------------
// osc52_base64_clipboard_framer
// base64 encoder that frames a message as a terminal set-clipboard sequence
// ----------------------------------------------------------------------------
// message bytes come in one beat each and leave as the bytes of
// ESC ] 5 2 ; c ; <base64> BEL, one byte per output beat, with out_last on the
// closing byte; with the wrap register set the sequence is framed for a
// terminal multiplexer (ESC P name ; first, the inner ESC doubled, ESC \ last).
// the front end takes one byte per cycle while the queue is not full, groups
// bytes in threes and pushes one command per beat into a short queue; the
// back end is a sequencer that emits one character per cycle while the
// receiver is ready. a byte that only joins a group adds no base64 character,
// a byte that completes a group adds four base64 characters. the first byte adds
// 7 prefix characters (15 with wrapping), the last byte adds up to 4 padded
// base64 characters and BEL (plus ESC \ with wrapping). an empty message is one
// beat with no_data and last_byte set. the wrap register is sampled per byte
// and should be written only while the block is idle
// ----------------------------------------------------------------------------
module osc52_base64_clipboard_framer import ocf_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  // message bytes
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ocf_in_t  in_data_i,
  // escape sequence bytes
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ocf_out_t out_data_o,
  // wrap register write
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic     cfg_data_i
);

  logic     push, pop, q_full, q_empty;
  ocf_cmd_t push_cmd, head_cmd;

  // byte grouping and command classification
  ocf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // decouples byte intake from character output
  ocf_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .cmd_o  (head_cmd)
  );

  // character sequencer with registered output beat
  ocf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_cmd_i    (head_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### test/tb_osc52_base64_clipboard_framer.sv
// ----------------------------------------------------------------------------
// tb_osc52_base64_clipboard_framer
// self-checking bench for the base64 set-clipboard sequence framer
// ----------------------------------------------------------------------------
// message bytes go in on the input channel. A software copy of the framer
// turns each accepted beat into the characters it must produce: prefix,
// base64 quads, padding, BEL and the optional multiplexer frame. Those
// characters queue up, and every output beat is checked against the oldest
// one. Directed tests cover padding, the alphabet ends, the no_data cases and
// the wrap register, including a change in the middle of a message. Random
// messages follow with idle bursts on both sides, one long receiver hold and
// a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_osc52_base64_clipboard_framer;
  import ocf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles to let the block settle once the last expected character is out
  localparam int unsigned SettleCycles = 40;
  // length of the forced receiver stall
  localparam int unsigned LongHold     = 250;

  // ESC ] 5 2 ; c ;
  localparam logic [55:0]  OscSeq  = {ESC_CODE, 8'h5D, 8'h35, 8'h32, 8'h3B, 8'h63, 8'h3B};
  // ESC P, multiplexer name, ;
  localparam logic [55:0]  PassSeq = {ESC_CODE, 8'h50, 8'h74, 8'h6D, 8'h75, 8'h78, 8'h3B};
  localparam logic [511:0] B64Set  =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  ocf_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  ocf_out_t out_data_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic     cfg_data_i;

  osc52_base64_clipboard_framer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // framer copy: wrap register, held bytes and message state
  // --------------------------------------------------------------------------
  logic       wrap_q      = 1'b0;
  logic [7:0] held0       = 8'h00;
  logic [7:0] held1       = 8'h00;
  logic [1:0] held_cnt    = 2'd0;
  logic       msg_open    = 1'b0;

  logic [7:0] step_chars[$];   // characters of the beat being framed
  ocf_out_t   exp_chars_q[$];  // characters still owed by the block

  int unsigned err_cnt  = 0;
  int unsigned beat_cnt = 0;
  bit          gaps_on  = 1'b0;
  bit          hold_req  = 1'b0;
  bit          hold_busy = 1'b0;

  function automatic logic [7:0] b64_at(input logic [5:0] idx);
    return B64Set[511 - 8 * idx -: 8];
  endfunction

  // inner byte, with ESC doubled when the multiplexer frame is on
  function automatic void put_inner(input logic [7:0] c);
    step_chars.push_back(c);
    if (wrap_q && c == ESC_CODE) begin
      step_chars.push_back(c);
    end
  endfunction

  // four base64 characters, the ones past nchars replaced by padding
  function automatic void put_quad(input logic [23:0] w, input int nchars);
    int k;
    for (k = 0; k < 4; k++) begin
      if (k < nchars) begin
        put_inner(b64_at(w[23 - 6 * k -: 6]));
      end else begin
        put_inner(PAD_CODE);
      end
    end
  endfunction

  // characters caused by one accepted message beat
  function automatic void frame_beat(input ocf_in_t b);
    int       k;
    ocf_out_t e;
    step_chars.delete();
    // a new message opens with the prefix, framed first when wrapping
    if (!msg_open) begin
      if (wrap_q) begin
        for (k = 0; k < 7; k++) begin
          step_chars.push_back(PassSeq[55 - 8 * k -: 8]);
        end
      end
      for (k = 0; k < 7; k++) begin
        put_inner(OscSeq[55 - 8 * k -: 8]);
      end
      msg_open = 1'b1;
      held_cnt = 2'd0;
    end
    // a data byte either joins the group or completes it
    if (!b.no_data) begin
      if (held_cnt == 2'd2) begin
        put_quad({held0, held1, b.data_byte}, 4);
        held_cnt = 2'd0;
      end else begin
        if (held_cnt == 2'd0) begin
          held0 = b.data_byte;
        end else begin
          held1 = b.data_byte;
        end
        held_cnt = held_cnt + 2'd1;
      end
    end
    // closing: padded remainder, BEL, then the frame end when wrapping
    if (b.last_byte) begin
      if (held_cnt == 2'd1) begin
        put_quad({held0, 16'h0000}, 2);
      end else if (held_cnt == 2'd2) begin
        put_quad({held0, held1, 8'h00}, 3);
      end
      put_inner(BEL_CODE);
      if (wrap_q) begin
        step_chars.push_back(ESC_CODE);
        step_chars.push_back(BSL_CODE);
      end
      held_cnt = 2'd0;
      msg_open = 1'b0;
    end
    for (k = 0; k < step_chars.size(); k++) begin
      e.out_char = step_chars[k];
      e.out_last = b.last_byte && (k == step_chars.size() - 1);
      exp_chars_q.push_back(e);
    end
  endfunction

  // --------------------------------------------------------------------------
  // clock, limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // several times the slowest legal run
  initial begin
    #1_000_000;
    $display("tb_osc52_base64_clipboard_framer failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // monitor: framing on input beats, checking on output beats
  // --------------------------------------------------------------------------
  // everything is sampled at the edge, before the edge's own updates land,
  // so the order of processes inside the step does not matter
  always @(posedge clk_i) begin
    ocf_out_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        wrap_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        frame_beat(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (exp_chars_q.size() == 0) begin
          $display("%0t: unexpected char, actual %h last %b",
                   $realtime, out_data_o.out_char, out_data_o.out_last);
          err_cnt++;
        end else begin
          want = exp_chars_q.pop_front();
          if (out_data_o.out_char !== want.out_char) begin
            $display("%0t: out_char expected %h actual %h",
                     $realtime, want.out_char, out_data_o.out_char);
            err_cnt++;
          end
          if (out_data_o.out_last !== want.out_last) begin
            $display("%0t: out_last expected %b actual %b",
                     $realtime, want.out_last, out_data_o.out_last);
            err_cnt++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random ready bursts, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      if (hold_req) begin
        hold_busy = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req  = 1'b0;
        hold_busy = 1'b0;
      end else if (gaps_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  // one message beat; called and returning at a rising edge
  task automatic send_beat(input logic [7:0] data, input logic last, input logic none);
    ocf_in_t b;
    b.data_byte = data;
    b.last_byte = last;
    b.no_data   = none;
    // random idle burst ahead of the beat
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    beat_cnt++;
  endtask

  // stop offering and wait until every owed character is out
  task automatic drain_sequence();
    in_valid_i <= 1'b0;
    // let the beat accepted at this edge be framed before the queue is checked
    @(posedge clk_i);
    while (exp_chars_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write, block idle
  task automatic write_wrap(input logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // whole message of random bytes, mostly well formed
  task automatic send_message(input int max_len);
    int len;
    int i;
    int shape;
    len   = $urandom_range(1, max_len);
    shape = $urandom_range(0, 11);
    if (shape == 0) begin
      // empty message
      send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end else begin
      for (i = 0; i < len; i++) begin
        // stray no_data beat inside the message
        if ($urandom_range(0, 9) == 0) begin
          send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        if (shape == 1 && i == len - 1) begin
          // closed by no_data with the bytes still held
          send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end else begin
          send_beat(8'($urandom_range(0, 255)), i == len - 1, 1'b0);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // empty message with the register at its reset value
  task automatic test_empty_message();
    send_beat(8'h00, 1'b1, 1'b1);
    drain_sequence();
  endtask

  // one, two and three byte messages: double pad, single pad, no pad
  task automatic test_tail_padding();
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    drain_sequence();
  endtask

  // all-zero, all-one and all-plus quads hit both ends of the alphabet
  task automatic test_alphabet_ends();
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'hFB, 1'b0, 1'b0);
    send_beat(8'hEF, 1'b0, 1'b0);
    send_beat(8'hBE, 1'b1, 1'b0);
    drain_sequence();
  endtask

  // no_data opening a message, inside it, and closing it with bytes held
  task automatic test_no_data_beats();
    send_beat(8'hA5, 1'b0, 1'b1);
    send_beat(8'h5A, 1'b0, 1'b0);
    send_beat(8'hC3, 1'b0, 1'b1);
    send_beat(8'h3C, 1'b1, 1'b1);
    drain_sequence();
  endtask

  // multiplexer frame: empty message and short messages
  task automatic test_wrap_framing();
    write_wrap(1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'h1B, 1'b1, 1'b0);
    send_beat(8'h1B, 1'b0, 1'b0);
    send_beat(8'h07, 1'b1, 1'b0);
    drain_sequence();
    write_wrap(1'b0);
  endtask

  // register flipped while a message is open: each beat uses the new value
  task automatic test_wrap_change_mid_message();
    send_beat(8'h12, 1'b0, 1'b0);
    send_beat(8'h34, 1'b0, 1'b0);
    drain_sequence();
    write_wrap(1'b1);
    send_beat(8'h56, 1'b1, 1'b0);
    drain_sequence();
    write_wrap(1'b0);
  endtask

  // long receiver stall while the sender keeps pushing, then a full drain
  task automatic test_backpressure();
    hold_req = 1'b1;
    while (!hold_busy) @(posedge clk_i);
    send_message(40);
    send_message(40);
    drain_sequence();
  endtask

  // random messages in phases, register changed between phases
  task automatic test_random_traffic();
    int ph;
    int unsigned start;
    gaps_on = 1'b1;
    for (ph = 0; ph < 4; ph++) begin
      // first two phases pin both register values
      write_wrap(ph < 2 ? logic'(ph) : logic'($urandom_range(0, 1)));
      start = beat_cnt;
      while (beat_cnt - start < 30) begin
        send_message($urandom_range(0, 7) == 0 ? 40 : 12);
      end
      drain_sequence();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    int unsigned start;
    gaps_on = 1'b0;
    write_wrap(logic'($urandom_range(0, 1)));
    start = beat_cnt;
    while (beat_cnt - start < 30) begin
      send_message(12);
    end
    drain_sequence();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_message();
    test_tail_padding();
    test_alphabet_ends();
    test_no_data_beats();
    test_wrap_framing();
    test_wrap_change_mid_message();
    gaps_on = 1'b1;
    test_backpressure();
    test_random_traffic();
    test_full_rate();

    if (err_cnt == 0) begin
      $display("tb_osc52_base64_clipboard_framer passed");
    end else begin
      $display("tb_osc52_base64_clipboard_framer failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/ocf_pkg.sv
sv/ocf_front.sv
sv/ocf_queue.sv
sv/ocf_back.sv
sv/osc52_base64_clipboard_framer.sv
test/tb_osc52_base64_clipboard_framer.sv
